### sv/lcdcls_pkg.sv
// Shared types and constants for the LCD command list sequencer.
package lcdcls_pkg;

  localparam int MAX_ARGS   = 31;
  localparam int COORD_BITS = 10;

  localparam int ARGS_W  = 5;
  localparam int CMDS_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int PIX_W   = 22;
  localparam int SEND_W  = 16;
  localparam int SPAN_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * SPAN_W;
  localparam int PIXC_W  = (PROD_W + 1 > PIX_W) ? PROD_W + 1 : PIX_W + 1;
  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET = 2'd1;
  localparam logic [BYTE_W-1:0] COL_OFFSET_RESET = 8'd26;
  localparam logic [BYTE_W-1:0] ROW_OFFSET_RESET = 8'd1;

  localparam int FLAG_DELAY_BIT = 7;

  localparam logic [BYTE_W-1:0] CMD_COL_SET   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_SET   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEM_WRITE = 8'h2C;

  localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELAY = 2'd2;

  // window burst step numbers
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CASET = 4'd0;
  localparam logic [STEP_W-1:0] STEP_XS_HI = 4'd1;
  localparam logic [STEP_W-1:0] STEP_XS_LO = 4'd2;
  localparam logic [STEP_W-1:0] STEP_XE_HI = 4'd3;
  localparam logic [STEP_W-1:0] STEP_XE_LO = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RASET = 4'd5;
  localparam logic [STEP_W-1:0] STEP_YS_HI = 4'd6;
  localparam logic [STEP_W-1:0] STEP_YS_LO = 4'd7;
  localparam logic [STEP_W-1:0] STEP_YE_HI = 4'd8;
  localparam logic [STEP_W-1:0] STEP_YE_LO = 4'd9;
  localparam logic [STEP_W-1:0] STEP_RAMWR = 4'd10;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_CODE  = 5'b00010,
    PH_FLAG  = 5'b00100,
    PH_ARGS  = 5'b01000,
    PH_DELAY = 5'b10000
  } phase_t;

  // one queued job: a single list result or a whole window burst
  typedef struct packed {
    logic              is_win;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              tend;
    logic              done;
    logic [SEND_W-1:0] xs;
    logic [SEND_W-1:0] xe;
    logic [SEND_W-1:0] ys;
    logic [SEND_W-1:0] ye;
    logic [SPAN_W-1:0] dx;
    logic [SPAN_W-1:0] dy;
    logic              rev;
  } q_entry_t;

endpackage

### sv/lcdcls_front.sv
// Front end: accepts words, parses the command list, classifies work into queue entries.
module lcdcls_front import lcdcls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [BYTE_W-1:0]     list_byte,
  input  logic                  list_start,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [BYTE_W-1:0]     col_offset,
  input  logic [BYTE_W-1:0]     row_offset,
  output logic                  push_valid,
  input  logic                  push_ready,
  output q_entry_t              push_entry
);

  phase_t            phase, phase_next;
  logic [CMDS_W-1:0] commands_left, commands_left_next;
  logic [ARGS_W-1:0] args_left, args_left_next;
  logic              delay_pending, delay_pending_next;
  logic [BYTE_W-1:0] held_command, held_command_next;

  logic              accept;
  logic              list_res;
  logic [ARGS_W-1:0] nargs;
  logic [ARGS_W-1:0] args_dec;
  logic [CMDS_W-1:0] cmds_dec;
  logic              last_cmd;
  logic              flag_delay;
  q_entry_t          res;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign cmds_dec = commands_left - CMDS_W'(1);
  assign args_dec = args_left - ARGS_W'(1);
  assign last_cmd = (commands_left == CMDS_W'(1));
  assign flag_delay = list_byte[FLAG_DELAY_BIT];
  assign nargs = (list_byte[ARGS_W-1:0] > ARGS_W'(MAX_ARGS)) ? ARGS_W'(MAX_ARGS)
                                                             : list_byte[ARGS_W-1:0];

  always_comb begin
    phase_next         = phase;
    commands_left_next = commands_left;
    args_left_next     = args_left;
    delay_pending_next = delay_pending;
    held_command_next  = held_command;
    list_res           = 1'b0;
    res                = '0;
    if (list_start) begin
      commands_left_next = list_byte;
      args_left_next     = '0;
      delay_pending_next = 1'b0;
      phase_next         = (list_byte == '0) ? PH_IDLE : PH_CODE;
    end else begin
      unique case (phase)
        PH_CODE: begin
          held_command_next = list_byte;
          phase_next        = PH_FLAG;
        end
        PH_FLAG: begin
          list_res           = 1'b1;
          res.kind           = KIND_CMD;
          res.data           = held_command;
          res.tend           = 1'b1;
          res.done           = last_cmd && (nargs == '0) && !flag_delay;
          delay_pending_next = flag_delay;
          if (nargs != '0) begin
            args_left_next = nargs;
            phase_next     = PH_ARGS;
          end else if (flag_delay) begin
            phase_next = PH_DELAY;
          end else begin
            commands_left_next = cmds_dec;
            phase_next         = (cmds_dec == '0) ? PH_IDLE : PH_CODE;
          end
        end
        PH_ARGS: begin
          list_res       = 1'b1;
          res.kind       = KIND_DATA;
          res.data       = list_byte;
          args_left_next = args_dec;
          if (args_dec != '0) begin
            res.tend = 1'b0;
          end else if (delay_pending) begin
            res.tend   = 1'b1;
            phase_next = PH_DELAY;
          end else begin
            res.tend           = 1'b1;
            res.done           = last_cmd;
            commands_left_next = cmds_dec;
            phase_next         = (cmds_dec == '0) ? PH_IDLE : PH_CODE;
          end
        end
        PH_DELAY: begin
          list_res           = 1'b1;
          res.kind           = KIND_DELAY;
          res.data           = list_byte;
          res.done           = last_cmd;
          delay_pending_next = 1'b0;
          commands_left_next = cmds_dec;
          phase_next         = (cmds_dec == '0) ? PH_IDLE : PH_CODE;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // window entry: offsets added here, span product left to the back end
  always_comb begin
    push_entry = res;
    if (req_type) begin
      push_entry        = '0;
      push_entry.is_win = 1'b1;
      push_entry.xs     = SEND_W'(x_start) + SEND_W'(col_offset);
      push_entry.xe     = SEND_W'(x_end) + SEND_W'(col_offset);
      push_entry.ys     = SEND_W'(y_start) + SEND_W'(row_offset);
      push_entry.ye     = SEND_W'(y_end) + SEND_W'(row_offset);
      push_entry.dx     = SPAN_W'(x_end) - SPAN_W'(x_start) + SPAN_W'(1);
      push_entry.dy     = SPAN_W'(y_end) - SPAN_W'(y_start) + SPAN_W'(1);
      push_entry.rev    = (x_end < x_start) || (y_end < y_start);
    end
  end

  assign push_valid = accept && (req_type || list_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      commands_left <= '0;
      args_left     <= '0;
      delay_pending <= 1'b0;
      held_command  <= '0;
    end else if (accept && !req_type) begin
      phase         <= phase_next;
      commands_left <= commands_left_next;
      args_left     <= args_left_next;
      delay_pending <= delay_pending_next;
      held_command  <= held_command_next;
    end
  end

endmodule

### sv/lcdcls_queue.sv
// Short job queue between the front end and the back end.
module lcdcls_queue import lcdcls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_entry
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("queue push while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

### sv/lcdcls_back.sv
// Back end: pops jobs and drives the output register, stepping through window bursts.
module lcdcls_back import lcdcls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  q_entry_t          pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [BYTE_W-1:0] out_byte,
  output logic              transfer_end,
  output logic              list_done,
  output logic [PIX_W-1:0]  pixel_bytes,
  output logic              last
);

  logic              adv;
  logic              win_active;
  logic [STEP_W-1:0] step;
  logic [SEND_W-1:0] xs, xe, ys, ye;
  logic [PROD_W-1:0] prod;
  logic [PIXC_W-1:0] pix_wide;
  logic [PIX_W-1:0]  pix_sat;

  logic [KIND_W-1:0] w_kind;
  logic [BYTE_W-1:0] w_byte;
  logic              w_tend;

  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv && !win_active;
  assign pix_wide  = PIXC_W'(prod) << 1;
  assign pix_sat   = (pix_wide > PIXC_W'(PIX_MAX)) ? PIX_MAX : pix_wide[PIX_W-1:0];

  always_comb begin
    w_kind = KIND_DATA;
    w_byte = '0;
    w_tend = 1'b0;
    case (step)
      STEP_XS_HI: w_byte = xs[SEND_W-1:BYTE_W];
      STEP_XS_LO: w_byte = xs[BYTE_W-1:0];
      STEP_XE_HI: w_byte = xe[SEND_W-1:BYTE_W];
      STEP_XE_LO: begin
        w_byte = xe[BYTE_W-1:0];
        w_tend = 1'b1;
      end
      STEP_RASET: begin
        w_kind = KIND_CMD;
        w_byte = CMD_ROW_SET;
        w_tend = 1'b1;
      end
      STEP_YS_HI: w_byte = ys[SEND_W-1:BYTE_W];
      STEP_YS_LO: w_byte = ys[BYTE_W-1:0];
      STEP_YE_HI: w_byte = ye[SEND_W-1:BYTE_W];
      STEP_YE_LO: begin
        w_byte = ye[BYTE_W-1:0];
        w_tend = 1'b1;
      end
      STEP_RAMWR: begin
        w_kind = KIND_CMD;
        w_byte = CMD_MEM_WRITE;
        w_tend = 1'b1;
      end
      default: begin
        w_kind = KIND_CMD;
        w_byte = CMD_COL_SET;
        w_tend = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      win_active <= 1'b0;
      step       <= STEP_CASET;
    end else if (adv) begin
      if (win_active) begin
        out_valid <= 1'b1;
        step      <= step + STEP_W'(1);
        if (step == STEP_RAMWR) begin
          win_active <= 1'b0;
        end
      end else if (pop_valid) begin
        out_valid <= 1'b1;
        if (pop_entry.is_win) begin
          win_active <= 1'b1;
          step       <= STEP_XS_HI;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (win_active) begin
        out_kind     <= w_kind;
        out_byte     <= w_byte;
        transfer_end <= w_tend;
        list_done    <= 1'b0;
        pixel_bytes  <= (step == STEP_RAMWR) ? pix_sat : '0;
        last         <= (step == STEP_RAMWR);
      end else if (pop_valid) begin
        if (pop_entry.is_win) begin
          out_kind     <= KIND_CMD;
          out_byte     <= CMD_COL_SET;
          transfer_end <= 1'b1;
          list_done    <= 1'b0;
          pixel_bytes  <= '0;
          last         <= 1'b0;
          xs           <= pop_entry.xs;
          xe           <= pop_entry.xe;
          ys           <= pop_entry.ys;
          ye           <= pop_entry.ye;
          prod         <= pop_entry.rev ? '0 : pop_entry.dx * pop_entry.dy;
        end else begin
          out_kind     <= pop_entry.kind;
          out_byte     <= pop_entry.data;
          transfer_end <= pop_entry.tend;
          list_done    <= pop_entry.done;
          pixel_bytes  <= '0;
          last         <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    win_active |-> step <= STEP_RAMWR && step != STEP_CASET)
    else $error("window step out of range");
  a_pix_on_ramwr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_bytes != '0) |-> (out_kind == KIND_CMD && out_byte == CMD_MEM_WRITE
                                          && last && !list_done))
    else $error("pixel count outside memory write");
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    win_active |-> out_valid && !last)
    else $error("window burst lost its output");
`endif

endmodule

### sv/lcd_command_list_sequencer.sv
// Top level of the LCD command list sequencer: config registers, front end, queue, back end.
// A list word is accepted every cycle while the 4-entry job queue has room and yields at
// most one result, held in the queue, then in the output register. A window yields 11
// results, one per cycle unless the output stalls, stepped by the back end's burst
// counter; no job is popped mid-burst, while list words fill the queue. The output
// is registered, so results can stall without stopping input until the queue fills.
module lcd_command_list_sequencer import lcdcls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [BYTE_W-1:0]     list_byte,
  input  logic                  list_start,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  transfer_end,
  output logic                  list_done,
  output logic [PIX_W-1:0]      pixel_bytes,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data
);

  logic [BYTE_W-1:0] col_offset;
  logic [BYTE_W-1:0] row_offset;
  logic              q_push_valid;
  logic              q_push_ready;
  q_entry_t          q_push_entry;
  logic              q_pop_valid;
  logic              q_pop_ready;
  q_entry_t          q_pop_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_offset <= COL_OFFSET_RESET;
      row_offset <= ROW_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COL_OFFSET: col_offset <= cfg_data;
        REG_ROW_OFFSET: row_offset <= cfg_data;
        default: begin
          col_offset <= col_offset;
        end
      endcase
    end
  end

  lcdcls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .list_byte  (list_byte),
    .list_start (list_start),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .col_offset (col_offset),
    .row_offset (row_offset),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_entry (q_push_entry)
  );

  lcdcls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_entry (q_push_entry),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_entry  (q_pop_entry)
  );

  lcdcls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (q_pop_valid),
    .pop_ready    (q_pop_ready),
    .pop_entry    (q_pop_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .transfer_end (transfer_end),
    .list_done    (list_done),
    .pixel_bytes  (pixel_bytes),
    .last         (last)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the LCD command list sequencer: list and window words, offsets.
`timescale 1ns / 1ps

module tb_top import lcdcls_pkg::*; ();

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_WORDS = 24;
  localparam int MAX_PRINTED = 100;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic                  req_type;
    logic [BYTE_W-1:0]     list_byte;
    logic                  list_start;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } lcd_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              tend;
    logic              done;
    logic [PIX_W-1:0]  pix;
    logic              last;
  } link_byte_t;

  class lcd_link_scoreboard;
    logic [BYTE_W-1:0] col_offset;
    logic [BYTE_W-1:0] row_offset;
    phase_t            phase;
    logic [CMDS_W-1:0] cmds_left;
    logic [ARGS_W-1:0] args_left;
    logic              delay_pending;
    logic [BYTE_W-1:0] held_code;
    link_byte_t        expected_bytes[$];
    int                mismatches;

    function new();
      col_offset = COL_OFFSET_RESET;
      row_offset = ROW_OFFSET_RESET;
      phase = PH_IDLE;
      cmds_left = '0;
      args_left = '0;
      delay_pending = 1'b0;
      held_code = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        REG_COL_OFFSET: col_offset = val;
        REG_ROW_OFFSET: row_offset = val;
        default: ;
      endcase
    endfunction

    function void push_byte(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data, logic tend,
                            logic done, logic [PIX_W-1:0] pix);
      link_byte_t e;
      e.kind = kind;
      e.data = data;
      e.tend = tend;
      e.done = done;
      e.pix = pix;
      e.last = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void end_command();
      cmds_left = cmds_left - CMDS_W'(1);
      phase = (cmds_left == 0) ? PH_IDLE : PH_CODE;
    endfunction

    function void predict_list_byte(logic [BYTE_W-1:0] b, logic start);
      int nargs;
      if (start) begin
        cmds_left = b;
        args_left = '0;
        delay_pending = 1'b0;
        phase = (b == 0) ? PH_IDLE : PH_CODE;
      end else begin
        case (phase)
          PH_CODE: begin
            held_code = b;
            phase = PH_FLAG;
          end
          PH_FLAG: begin
            nargs = int'(b[ARGS_W-1:0]);
            if (nargs > MAX_ARGS) nargs = MAX_ARGS;
            delay_pending = b[FLAG_DELAY_BIT];
            push_byte(KIND_CMD, held_code, 1'b1,
                      cmds_left == 1 && nargs == 0 && !delay_pending, '0);
            if (nargs > 0) begin
              args_left = nargs[ARGS_W-1:0];
              phase = PH_ARGS;
            end else if (delay_pending) begin
              phase = PH_DELAY;
            end else begin
              end_command();
            end
          end
          PH_ARGS: begin
            args_left = args_left - ARGS_W'(1);
            if (args_left != 0) begin
              push_byte(KIND_DATA, b, 1'b0, 1'b0, '0);
            end else if (delay_pending) begin
              push_byte(KIND_DATA, b, 1'b1, 1'b0, '0);
              phase = PH_DELAY;
            end else begin
              push_byte(KIND_DATA, b, 1'b1, cmds_left == 1, '0);
              end_command();
            end
          end
          PH_DELAY: begin
            push_byte(KIND_DELAY, b, 1'b0, cmds_left == 1, '0);
            delay_pending = 1'b0;
            end_command();
          end
          default: ;
        endcase
      end
    endfunction

    function void predict_window(lcd_req_t r);
      int unsigned area;
      logic [SEND_W-1:0] xs, xe, ys, ye;
      area = 0;
      if (r.x_end >= r.x_start && r.y_end >= r.y_start) begin
        area = (int'(r.x_end) - int'(r.x_start) + 1) * (int'(r.y_end) - int'(r.y_start) + 1) * 2;
        if (area > PIX_MAX) area = 32'(PIX_MAX);
      end
      xs = SEND_W'(r.x_start) + SEND_W'(col_offset);
      xe = SEND_W'(r.x_end) + SEND_W'(col_offset);
      ys = SEND_W'(r.y_start) + SEND_W'(row_offset);
      ye = SEND_W'(r.y_end) + SEND_W'(row_offset);
      push_byte(KIND_CMD, CMD_COL_SET, 1'b1, 1'b0, '0);
      push_byte(KIND_DATA, xs[15:8], 1'b0, 1'b0, '0);
      push_byte(KIND_DATA, xs[7:0], 1'b0, 1'b0, '0);
      push_byte(KIND_DATA, xe[15:8], 1'b0, 1'b0, '0);
      push_byte(KIND_DATA, xe[7:0], 1'b1, 1'b0, '0);
      push_byte(KIND_CMD, CMD_ROW_SET, 1'b1, 1'b0, '0);
      push_byte(KIND_DATA, ys[15:8], 1'b0, 1'b0, '0);
      push_byte(KIND_DATA, ys[7:0], 1'b0, 1'b0, '0);
      push_byte(KIND_DATA, ye[15:8], 1'b0, 1'b0, '0);
      push_byte(KIND_DATA, ye[7:0], 1'b1, 1'b0, '0);
      push_byte(KIND_CMD, CMD_MEM_WRITE, 1'b1, 1'b0, area[PIX_W-1:0]);
    endfunction

    // called for every accepted input word
    function void note_request(lcd_req_t r);
      int n_prior;
      n_prior = expected_bytes.size();
      if (r.req_type) predict_window(r);
      else predict_list_byte(r.list_byte, r.list_start);
      if (expected_bytes.size() > n_prior) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_link_byte(link_byte_t got);
      link_byte_t e;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected link byte kind %0d data %02h", got.kind, got.data));
      end else begin
        e = expected_bytes.pop_front();
        if (got.kind !== e.kind)
          report_mismatch($sformatf("out_kind %0d, expected %0d", got.kind, e.kind));
        if (got.data !== e.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", got.data, e.data));
        if (got.tend !== e.tend)
          report_mismatch($sformatf("transfer_end %0b, expected %0b", got.tend, e.tend));
        if (got.done !== e.done)
          report_mismatch($sformatf("list_done %0b, expected %0b", got.done, e.done));
        if (got.pix !== e.pix)
          report_mismatch($sformatf("pixel_bytes %0d, expected %0d", got.pix, e.pix));
        if (got.last !== e.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, e.last));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = 1'b0;
  logic [BYTE_W-1:0]     list_byte = '0;
  logic                  list_start = 1'b0;
  logic [COORD_BITS-1:0] x_start = '0;
  logic [COORD_BITS-1:0] y_start = '0;
  logic [COORD_BITS-1:0] x_end = '0;
  logic [COORD_BITS-1:0] y_end = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [BYTE_W-1:0]     out_byte;
  logic                  transfer_end;
  logic                  list_done;
  logic [PIX_W-1:0]      pixel_bytes;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0]     cfg_data = '0;

  lcd_link_scoreboard ledger;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  lcd_command_list_sequencer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .list_byte    (list_byte),
    .list_start   (list_start),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .transfer_end (transfer_end),
    .list_done    (list_done),
    .pixel_bytes  (pixel_bytes),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    link_byte_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.kind = out_kind;
      seen.data = out_byte;
      seen.tend = transfer_end;
      seen.done = list_done;
      seen.pix = pixel_bytes;
      seen.last = last;
      ledger.check_link_byte(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task sender_gap();
    int n;
    n = 0;
    while (n < 30 && $urandom_range(99) < send_idle_pct) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // entered and left at a falling edge
  task send_item(lcd_req_t r);
    in_valid <= 1'b1;
    req_type <= r.req_type;
    list_byte <= r.list_byte;
    list_start <= r.list_start;
    x_start <= r.x_start;
    y_start <= r.y_start;
    x_end <= r.x_end;
    y_end <= r.y_end;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(r);
    @(negedge clk);
    sender_gap();
  endtask

  task send_list_byte(logic [BYTE_W-1:0] b, logic start);
    lcd_req_t r;
    r = $bits(lcd_req_t)'({$urandom, $urandom});
    r.req_type = 1'b0;
    r.list_byte = b;
    r.list_start = start;
    // a stray word while idle is dropped by the block; don't count it
    if (start || ledger.phase != PH_IDLE) items_sent++;
    send_item(r);
  endtask

  task send_window(int xs, int ys, int xe, int ye);
    lcd_req_t r;
    r = $bits(lcd_req_t)'({$urandom, $urandom});
    r.req_type = 1'b1;
    r.x_start = COORD_BITS'(xs);
    r.y_start = COORD_BITS'(ys);
    r.x_end = COORD_BITS'(xe);
    r.y_end = COORD_BITS'(ye);
    items_sent++;
    send_item(r);
  endtask

  task send_random_window();
    int xs, ys, xe, ye, t;
    xs = $urandom_range(1023);
    ys = $urandom_range(1023);
    xe = $urandom_range(1023);
    ye = $urandom_range(1023);
    if ($urandom_range(1)) begin
      if (xs > xe) begin t = xs; xs = xe; xe = t; end
      if (ys > ye) begin t = ys; ys = ye; ye = t; end
    end
    send_window(xs, ys, xe, ye);
  endtask

  task send_random_list();
    logic [BYTE_W-1:0] body[$];
    logic [BYTE_W-1:0] flag;
    int n_cmds, n_args, cut;
    body = {};
    n_cmds = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 4);
    body.push_back(BYTE_W'(n_cmds));
    for (int c = 0; c < n_cmds && c < 5; c++) begin
      n_args = ($urandom_range(9) == 0) ? $urandom_range(5, MAX_ARGS) : $urandom_range(4);
      flag = BYTE_W'($urandom_range(255));
      flag[ARGS_W-1:0] = ARGS_W'(n_args);
      body.push_back(BYTE_W'($urandom_range(255)));
      body.push_back(flag);
      repeat (n_args) body.push_back(BYTE_W'($urandom_range(255)));
      if (flag[FLAG_DELAY_BIT]) body.push_back(BYTE_W'($urandom_range(255)));
    end
    cut = body.size();
    // now and then the next list start cuts this one short
    if ($urandom_range(9) == 0) cut = $urandom_range(1, body.size());
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(99) < 6) send_random_window();
      send_list_byte(body[i], i == 0);
    end
  endtask

  // hold input until every expected word is out, then let the pipe settle
  task wait_link_idle();
    in_valid <= 1'b0;
    while (ledger.expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    ledger = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: stray word, empty list, a full list, restart, windows
    send_list_byte(8'hA5, 1'b0);
    send_list_byte(8'h00, 1'b1);
    send_list_byte(8'h00, 1'b0);
    send_list_byte(8'd3, 1'b1);
    send_list_byte(8'h11, 1'b0);
    send_list_byte(8'h80, 1'b0);
    send_list_byte(8'hFF, 1'b0);
    send_list_byte(8'h3A, 1'b0);
    send_list_byte(8'h61, 1'b0);
    send_window(0, 0, 1023, 1023);
    send_list_byte(8'h05, 1'b0);
    send_list_byte(8'h29, 1'b0);
    send_list_byte(8'h00, 1'b0);
    send_list_byte(8'd2, 1'b1);
    send_list_byte(8'hB1, 1'b0);
    send_list_byte(8'h83, 1'b0);
    send_list_byte(8'h01, 1'b0);
    send_list_byte(8'd1, 1'b1);
    send_list_byte(8'h36, 1'b0);
    send_list_byte(8'h82, 1'b0);
    send_list_byte(8'h00, 1'b0);
    send_list_byte(8'hC8, 1'b0);
    send_list_byte(8'h0A, 1'b0);
    send_window(1023, 1023, 0, 0);
    send_window(5, 0, 4, 9);
    send_window(0, 9, 3, 2);
    send_window(1023, 0, 1023, 0);
    wait_link_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_register(REG_COL_OFFSET, 8'hFF);
          write_register(REG_ROW_OFFSET, 8'hFF);
        end
        1: begin
          send_idle_pct = 65;
          recv_stall_pct = 0;
          write_register(REG_COL_OFFSET, 8'h00);
          write_register(REG_ROW_OFFSET, 8'h00);
          write_register(REG_SPARE_2, BYTE_W'($urandom_range(255)));
          write_register(REG_SPARE_3, BYTE_W'($urandom_range(255)));
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 65;
          write_register(REG_COL_OFFSET, BYTE_W'($urandom_range(255)));
          write_register(REG_ROW_OFFSET, BYTE_W'($urandom_range(255)));
        end
        default: begin
          send_idle_pct = 30;
          recv_stall_pct = 30;
          write_register(REG_ROW_OFFSET, BYTE_W'($urandom_range(255)));
          write_register(REG_COL_OFFSET, BYTE_W'($urandom_range(255)));
        end
      endcase
      items_sent = 0;
      while (items_sent < PHASE_WORDS) begin
        case ($urandom_range(19))
          0, 1: send_random_window();
          2, 3: send_list_byte(BYTE_W'($urandom_range(255)), 1'b0);
          4: send_list_byte(8'h00, 1'b1);
          default: send_random_list();
        endcase
        if (items_sent >= PHASE_WORDS / 2 && items_sent < PHASE_WORDS / 2 + 6) wait_link_idle();
      end
      wait_link_idle();
    end

    if (ledger.mismatches == 0 && ledger.expected_bytes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
